// ===== rtl/ztt_pkg.sv =====
package ztt_pkg;

    // opcodes of a request
    localparam logic [2:0] OP_LOAD_KEY = 3'd0;
    localparam logic [2:0] OP_CLEAR    = 3'd1;
    localparam logic [2:0] OP_TOGGLE   = 3'd2;
    localparam logic [2:0] OP_LOOKUP   = 3'd3;
    localparam logic [2:0] OP_STORE    = 3'd4;

    // bound kinds of a table entry
    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    // request payload
    typedef struct packed {
        logic [2:0]         opcode;
        logic               table_sel;
        logic               piece;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [31:0]        key_short;
        logic [63:0]        key_long;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic [7:0]         search_depth;
        logic [1:0]         bound_kind;
        logic signed [15:0] score;
    } t_req;

    // response payload
    typedef struct packed {
        logic               hit;
        logic signed [15:0] score_out;
        logic [31:0]        hash_short;
        logic [63:0]        hash_long;
    } t_rsp;

    // one transposition table word
    typedef struct packed {
        logic               valid;
        logic [63:0]        tag;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [7:0]         depth;
    } t_entry;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_ADDR  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_EXEC  = 5'b10000
    } t_state;

endpackage

// ===== rtl/zobrist_transposition_table_unit.sv =====
// Zobrist board hash with two direct-mapped transposition tables.
// Request channel: i_req_valid / o_req_ready carry one t_req; opcode selects
// load key pair, clear hash, toggle piece, lookup or store.
// Response channel: o_rsp_valid / i_rsp_ready carry one t_rsp per request
// with the hit flag, the score on a hit and both hashes after the request.
// Each request walks a small sequencer: address, memory read, execute.
// A request goes from acceptance through the address, read and execute states
// to the response register; no new request is taken until the unit is idle.
// Read step: registered key/table read before the XOR or tag/bound compare.
// A single bound comparator serves both the lower and the upper bound test.
// After reset the hashes are zero and a clearing pass walks the table memory,
// one entry a cycle, 2 * 2**INDEX_BITS words (2048 by default); no request is
// taken during it. Key memory is not cleared: keys must be loaded before use.
// The response sits in an output register; a new request is taken while it
// waits, but that request stalls in its execute step until the response is
// taken, so nothing is lost or overwritten.
module zobrist_transposition_table_unit
    import ztt_pkg::*;
#(
    parameter int BOARD_SIZE = 15,
    parameter int INDEX_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int BS2       = BOARD_SIZE * BOARD_SIZE;
    localparam int KEY_DEPTH = 2 * BS2;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int TBL_AW    = INDEX_BITS + 1;
    localparam int TBL_DEPTH = 2 ** TBL_AW;

    t_state r_state, n_state;
    logic [TBL_AW-1:0] r_clr_addr, n_clr_addr;
    logic [31:0] r_hash_short, n_hash_short;
    logic [63:0] r_hash_long, n_hash_long;
    logic r_rsp_valid, n_rsp_valid;
    t_rsp r_rsp, n_rsp;

    t_req r_req;
    logic [KEY_AW-1:0] r_key_addr;
    logic r_key_ok;
    logic [TBL_AW-1:0] r_tbl_addr;

    logic [31:0] key_short_mem [KEY_DEPTH];
    logic [63:0] key_long_mem [KEY_DEPTH];
    logic [31:0] r_key_short_rd;
    logic [63:0] r_key_long_rd;
    t_entry tbl_mem [TBL_DEPTH];
    t_entry r_tbl_rd;

    logic exec_go;
    logic key_we;
    logic tbl_we;
    logic [TBL_AW-1:0] tbl_waddr;
    t_entry tbl_wdata;
    logic signed [15:0] bound_val;
    logic [16:0] bound_diff;
    logic score_ge;
    logic score_le;
    logic entry_match;
    logic lookup_hit;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // execute step may finish once the response register is free
    assign exec_go = (r_state == ST_EXEC) && (!r_rsp_valid || i_rsp_ready);

    // shared bound comparator: lower bound against beta, else alpha
    assign bound_val  = (r_tbl_rd.kind == KIND_LOWER) ? r_req.beta : r_req.alpha;
    assign bound_diff = {r_tbl_rd.score[15], r_tbl_rd.score} - {bound_val[15], bound_val};
    assign score_ge   = !bound_diff[16];
    assign score_le   = bound_diff[16] || (bound_diff == 17'd0);

    // tag and depth check, then kind rule
    assign entry_match = r_tbl_rd.valid && (r_tbl_rd.tag == r_hash_long)
                         && (r_tbl_rd.depth >= r_req.search_depth);
    always_comb begin
        lookup_hit = 1'b0;
        if (entry_match) begin
            unique case (r_tbl_rd.kind)
                KIND_EXACT: lookup_hit = 1'b1;
                KIND_LOWER: lookup_hit = score_ge;
                KIND_UPPER: lookup_hit = score_le;
                default:    lookup_hit = 1'b0;
            endcase
        end
    end

    // memory write controls
    assign key_we    = exec_go && (r_req.opcode == OP_LOAD_KEY) && r_key_ok;
    assign tbl_we    = (r_state == ST_CLEAR) || (exec_go && (r_req.opcode == OP_STORE));
    assign tbl_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_tbl_addr;
    always_comb begin
        tbl_wdata = '0;
        if (r_state != ST_CLEAR) begin
            tbl_wdata.valid = 1'b1;
            tbl_wdata.tag   = r_hash_long;
            tbl_wdata.kind  = r_req.bound_kind;
            tbl_wdata.score = r_req.score;
            tbl_wdata.depth = r_req.search_depth;
        end
    end

    // sequencer next state and response
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_hash_short = r_hash_short;
        n_hash_long  = r_hash_long;
        n_rsp_valid  = r_rsp_valid && !i_rsp_ready;
        n_rsp        = r_rsp;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) begin
                    if (r_req.opcode == OP_CLEAR) begin
                        n_hash_short = '0;
                        n_hash_long  = '0;
                    end else if (r_req.opcode == OP_TOGGLE && r_key_ok) begin
                        n_hash_short = r_hash_short ^ r_key_short_rd;
                        n_hash_long  = r_hash_long ^ r_key_long_rd;
                    end
                    n_rsp.hit        = (r_req.opcode == OP_LOOKUP) && lookup_hit;
                    n_rsp.score_out  = n_rsp.hit ? r_tbl_rd.score : 16'sd0;
                    n_rsp.hash_short = n_hash_short;
                    n_rsp.hash_long  = n_hash_long;
                    n_rsp_valid      = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_hash_short <= '0;
            r_hash_long  <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_hash_short <= n_hash_short;
            r_hash_long  <= n_hash_long;
            r_rsp_valid  <= n_rsp_valid;
        end
    end

    // payload registers: request capture, addresses, response
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (r_state == ST_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (r_state == ST_ADDR) begin
            r_key_ok   <= (32'(r_req.row) < BOARD_SIZE) && (32'(r_req.col) < BOARD_SIZE);
            r_key_addr <= KEY_AW'(32'(r_req.piece) * BS2 + 32'(r_req.row) * BOARD_SIZE
                                  + 32'(r_req.col));
            r_tbl_addr <= {r_req.table_sel, r_hash_short[INDEX_BITS-1:0]};
        end
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_short_mem[r_key_addr] <= r_req.key_short;
            key_long_mem[r_key_addr]  <= r_req.key_long;
        end
        r_key_short_rd <= key_short_mem[r_key_addr];
        r_key_long_rd  <= key_long_mem[r_key_addr];
    end

    // transposition table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd <= tbl_mem[r_tbl_addr];
    end

`ifndef NO_ASSERTIONS
    // an accepted request always goes to address generation
    a_accept_to_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == ST_ADDR))
        else $error("accepted request did not enter address step");

    // a new response only comes out of the execute step
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_rsp_valid)) |-> $past(r_state == ST_EXEC))
        else $error("response raised outside execute step");

    // the board hash changes only in the execute step
    a_hash_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_hash_long)) |-> $past(r_state == ST_EXEC))
        else $error("hash changed outside execute step");
`endif

endmodule
